/* hdl/qdpt_pkg.sv */
// shared types, codes and the edge table for the quadrature decoder
// no dependencies; every other file of the block refers to this package

package qdpt_pkg;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 8;
	localparam int CFG_SLOTS  = 4;
	localparam int SLOT_CNT_W = 8;
	localparam int MODE_W     = 2;

	// result field widths
	localparam int ROT_W  = 16;
	localparam int FLIP_W = 3;
	localparam int STEP_W = 2;

	// item kinds
	localparam logic ACT_EDGE   = 1'b0;
	localparam logic ACT_SAMPLE = 1'b1;

	localparam logic signed [STEP_W-1:0] STEP_NONE = 2'sb00;
	localparam logic signed [STEP_W-1:0] STEP_CW   = 2'sb01;
	localparam logic signed [STEP_W-1:0] STEP_CCW  = 2'sb11;

	typedef enum logic [MODE_W-1:0] {
		MODE_OFF  = 2'd0,
		MODE_CW   = 2'd1,
		MODE_CCW  = 2'd2,
		MODE_BOTH = 2'd3
	} mode_t;

	// edge machine phases; PH_CW / PH_CCW mark a confirmed detent and are never stored
	typedef enum logic [2:0] {
		PH_START = 3'd0,
		PH_A     = 3'd1,
		PH_B     = 3'd2,
		PH_C     = 3'd3,
		PH_D     = 3'd4,
		PH_CW    = 3'd5,
		PH_CCW   = 3'd6
	} phase_t;

	typedef struct packed {
		logic en;
		logic rising;
		logic b;
	} edge_req_t;

	typedef struct packed {
		logic step;
		logic ccw;
	} edge_step_t;

	typedef struct packed {
		logic en;
		logic ccw;
	} slot_req_t;

	// transition table, col = {b level, rising}
	function automatic phase_t next_phase(input phase_t row, input logic [1:0] col);
		phase_t nx;
		nx = PH_START;
		unique case (row)
			PH_A: begin
				unique case (col)
					2'd0: nx = PH_CCW;
					2'd1: nx = PH_A;
					2'd2: nx = PH_START;
					default: nx = PH_A;
				endcase
			end
			PH_B: begin
				unique case (col)
					2'd0: nx = PH_START;
					2'd1: nx = PH_B;
					2'd2: nx = PH_CW;
					default: nx = PH_B;
				endcase
			end
			PH_C: begin
				unique case (col)
					2'd0: nx = PH_C;
					2'd1: nx = PH_CW;
					2'd2: nx = PH_C;
					default: nx = PH_START;
				endcase
			end
			PH_D: begin
				unique case (col)
					2'd0: nx = PH_D;
					2'd1: nx = PH_START;
					2'd2: nx = PH_D;
					default: nx = PH_CCW;
				endcase
			end
			default: begin
				// start, and any code that is not a stored phase
				unique case (col)
					2'd0: nx = PH_D;
					2'd1: nx = PH_B;
					2'd2: nx = PH_C;
					default: nx = PH_A;
				endcase
			end
		endcase
		return nx;
	endfunction

endpackage

/* hdl/qdpt_edge.sv */
// channel A edge state machine: five-phase table walk, reports confirmed detents
// depends on qdpt_pkg

module qdpt_edge (
	input  logic                 clk,
	input  logic                 arst_n,
	input  qdpt_pkg::edge_req_t  req,
	output qdpt_pkg::edge_step_t step
);

	qdpt_pkg::phase_t phase_q;
	qdpt_pkg::phase_t phase_d;
	qdpt_pkg::phase_t lookup;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= qdpt_pkg::PH_START;
		end else begin
			phase_q <= phase_d;
		end
	end

	always_comb begin
		lookup   = qdpt_pkg::next_phase(phase_q, {req.b, req.rising});
		phase_d  = phase_q;
		step     = '0;
		if (req.en) begin
			unique case (lookup)
				qdpt_pkg::PH_CW: begin
					step.step = 1'b1;
					step.ccw  = 1'b0;
					phase_d   = qdpt_pkg::PH_START;
				end
				qdpt_pkg::PH_CCW: begin
					step.step = 1'b1;
					step.ccw  = 1'b1;
					phase_d   = qdpt_pkg::PH_START;
				end
				default: phase_d = lookup;
			endcase
		end
	end

endmodule

/* hdl/qdpt_slots.sv */
// prescaler trigger slots: per-slot count, mode and countdown, fire on zero
// depends on qdpt_pkg

module qdpt_slots #(
	parameter int SLOTS = 4
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [qdpt_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [qdpt_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  qdpt_pkg::slot_req_t               req,
	output logic [SLOTS-1:0]                  fire
);

	for (genvar i = 0; i < SLOTS; i++) begin : g_slot
		if (i < qdpt_pkg::CFG_SLOTS) begin : g_live
			logic [qdpt_pkg::SLOT_CNT_W-1:0] count_q;
			logic [qdpt_pkg::SLOT_CNT_W-1:0] countdown_q;
			qdpt_pkg::mode_t                 mode_q;
			logic                            wr_count;
			logic                            wr_mode;
			logic                            active;
			logic                            match;
			logic                            hit;

			assign wr_count = cfg_we && (cfg_index == qdpt_pkg::CFG_IDX_W'(i));
			assign wr_mode  = cfg_we &&
				(cfg_index == qdpt_pkg::CFG_IDX_W'(qdpt_pkg::CFG_SLOTS + i));

			always_comb begin
				active = req.en && (mode_q != qdpt_pkg::MODE_OFF);
				match  = (mode_q == qdpt_pkg::MODE_BOTH) ||
					((mode_q == qdpt_pkg::MODE_CW) && !req.ccw) ||
					((mode_q == qdpt_pkg::MODE_CCW) && req.ccw);
				// zero acts like one
				hit    = active && match &&
					(countdown_q <= qdpt_pkg::SLOT_CNT_W'(1));
			end

			assign fire[i] = hit;

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					count_q     <= qdpt_pkg::SLOT_CNT_W'(1);
					countdown_q <= qdpt_pkg::SLOT_CNT_W'(1);
					mode_q      <= qdpt_pkg::MODE_OFF;
				end else if (wr_count) begin
					count_q     <= cfg_data[qdpt_pkg::SLOT_CNT_W-1:0];
					countdown_q <= cfg_data[qdpt_pkg::SLOT_CNT_W-1:0];
				end else if (wr_mode) begin
					mode_q      <= qdpt_pkg::mode_t'(cfg_data[qdpt_pkg::MODE_W-1:0]);
					countdown_q <= count_q;
				end else if (active) begin
					if (!match || hit) begin
						countdown_q <= count_q;
					end else begin
						countdown_q <= countdown_q - qdpt_pkg::SLOT_CNT_W'(1);
					end
				end
			end
		end else begin : g_dead
			// no register reaches this slot, it stays disabled
			assign fire[i] = 1'b0;
		end
	end

endmodule

/* hdl/quadrature_decoder_prescaled_triggers_core.sv */
// top level of the rotary quadrature decoder with prescaled direction triggers
// depends on qdpt_pkg, qdpt_edge and qdpt_slots

// Takes one request per clock on the item channel while result_ready stays high, and
// returns exactly one result per request, in order. An accepted request lands in the
// input register, moves into the result register once that is free or being emptied,
// and its result is on the result channel from then on.
// Throughput is one request per cycle while result_ready stays high: the edge machine,
// the detent counter and all prescaler slots update as a request moves between the two
// registers. While a finished result waits for result_ready, the input register still
// takes one more request and item_ready then stays low until the result is taken.
// An edge request (action = 0) walks the five-phase table; a confirmed detent steps the
// signed wrapping count and is reported on step_dir. A sample request (action = 1) with
// a_flipped set counts by b_level when a_level is low, then updates every enabled slot
// with the latest direction; fire_mask shows the slots that reached zero. Configuration
// writes (index 0..3 slot counts, 4..7 slot modes) take effect at once, reload the
// slot's countdown, and must only be issued while no request is in flight.

module quadrature_decoder_prescaled_triggers_core #(
	parameter int SLOTS      = 4,
	parameter int COUNT_BITS = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,

	// configuration
	input  logic                                  cfg_we,
	input  logic [qdpt_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [qdpt_pkg::CFG_DATA_W-1:0]       cfg_data,

	// item channel
	input  logic                                  item_valid,
	output logic                                  item_ready,
	input  logic                                  action,
	input  logic                                  edge_rising,
	input  logic                                  b_level,
	input  logic                                  a_level,
	input  logic                                  a_flipped,
	input  logic                                  b_flipped,
	input  logic                                  button_flipped,

	// result channel
	output logic                                  result_valid,
	input  logic                                  result_ready,
	output logic signed [qdpt_pkg::STEP_W-1:0]    step_dir,
	output logic signed [qdpt_pkg::ROT_W-1:0]     rotation_count,
	output logic [qdpt_pkg::FLIP_W-1:0]           flip_mask,
	output logic [SLOTS-1:0]                      fire_mask
);

	// input register
	logic valid_s1;
	logic action_s1;
	logic edge_rising_s1;
	logic b_level_s1;
	logic a_level_s1;
	logic a_flipped_s1;
	logic b_flipped_s1;
	logic button_flipped_s1;

	// result register
	logic                               valid_s2;
	logic signed [qdpt_pkg::STEP_W-1:0] step_dir_s2;
	logic signed [qdpt_pkg::ROT_W-1:0]  rotation_count_s2;
	logic [qdpt_pkg::FLIP_W-1:0]        flip_mask_s2;
	logic [SLOTS-1:0]                   fire_mask_s2;

	// block state
	logic [COUNT_BITS-1:0] count_q;
	logic                  last_dir_ccw_q;

	logic                               adv;
	logic                               take;
	logic                               sample_go;
	logic                               cnt_step;
	logic                               cnt_ccw;
	logic                               dir_now;
	logic [COUNT_BITS-1:0]              count_d;
	logic signed [qdpt_pkg::ROT_W-1:0]  rot_d;
	logic signed [qdpt_pkg::STEP_W-1:0] step_dir_d;
	logic [qdpt_pkg::FLIP_W-1:0]        flip_d;
	logic [SLOTS-1:0]                   fire_d;

	qdpt_pkg::edge_req_t  edge_req;
	qdpt_pkg::edge_step_t edge_step;
	qdpt_pkg::slot_req_t  slot_req;

	// handshake: stage 1 moves on whenever the result register is free or being emptied
	assign adv        = valid_s1 && (!valid_s2 || result_ready);
	assign item_ready = !valid_s1 || adv;
	assign take       = item_valid && item_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			action_s1         <= action;
			edge_rising_s1    <= edge_rising;
			b_level_s1        <= b_level;
			a_level_s1        <= a_level;
			a_flipped_s1      <= a_flipped;
			b_flipped_s1      <= b_flipped;
			button_flipped_s1 <= button_flipped;
		end
	end

	// edge machine only moves on edge requests
	assign edge_req.en     = adv && (action_s1 == qdpt_pkg::ACT_EDGE);
	assign edge_req.rising = edge_rising_s1;
	assign edge_req.b      = b_level_s1;

	qdpt_edge u_edge (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (edge_req),
		.step   (edge_step)
	);

	// a sample only does anything when debounced A flipped
	assign sample_go = adv && (action_s1 == qdpt_pkg::ACT_SAMPLE) && a_flipped_s1;

	always_comb begin
		cnt_step = edge_step.step || (sample_go && !a_level_s1);
		cnt_ccw  = edge_step.step ? edge_step.ccw : b_level_s1;
		// slots see the direction left by this request's own count step
		dir_now  = cnt_step ? cnt_ccw : last_dir_ccw_q;

		count_d = count_q;
		if (cnt_step) begin
			count_d = cnt_ccw ? (count_q - COUNT_BITS'(1)) : (count_q + COUNT_BITS'(1));
		end

		step_dir_d = qdpt_pkg::STEP_NONE;
		if (edge_step.step) begin
			step_dir_d = edge_step.ccw ? qdpt_pkg::STEP_CCW : qdpt_pkg::STEP_CW;
		end

		flip_d = '0;
		if (sample_go) begin
			flip_d = {button_flipped_s1, b_flipped_s1, 1'b1};
		end
	end

	// reported count is the low result-width bits, zero filled for a narrow counter
	if (COUNT_BITS >= qdpt_pkg::ROT_W) begin : g_rot_trunc
		assign rot_d = count_d[qdpt_pkg::ROT_W-1:0];
	end else begin : g_rot_ext
		assign rot_d = {{(qdpt_pkg::ROT_W-COUNT_BITS){1'b0}}, count_d};
	end

	assign slot_req.en  = sample_go;
	assign slot_req.ccw = dir_now;

	qdpt_slots #(
		.SLOTS (SLOTS)
	) u_slots (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (slot_req),
		.fire      (fire_d)
	);

	// counter and last direction commit together with the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q        <= '0;
			last_dir_ccw_q <= 1'b0;
		end else if (cnt_step) begin
			count_q        <= count_d;
			last_dir_ccw_q <= cnt_ccw;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (result_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			step_dir_s2       <= step_dir_d;
			rotation_count_s2 <= rot_d;
			flip_mask_s2      <= flip_d;
			fire_mask_s2      <= fire_d;
		end
	end

	assign result_valid   = valid_s2;
	assign step_dir       = step_dir_s2;
	assign rotation_count = rotation_count_s2;
	assign flip_mask      = flip_mask_s2;
	assign fire_mask      = fire_mask_s2;

endmodule
